FILE: design/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and codes for the two-symbol Turing machine stepper.
// ----------------------------------------------------------------------------
package tsm_pkg;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_STEP    = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HALTED   = 2'd1,
        ST_OFF_TAPE = 2'd2,
        ST_BAD_CARD = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } t_back_state;

    // classified input word
    typedef struct packed {
        t_op         op;
        logic        slot_ok;
        logic [7:0]  card_index;
        logic [31:0] card_word;
        logic        cell_ok;
        logic [9:0]  cell_index;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [13:0] machine_state;
        logic [9:0]  head_position;
        logic        cell_value;
    } t_result;

    // back part status seen by the front part
    typedef struct packed {
        logic take;
        logic init_busy;
    } t_back_stat;

endpackage

FILE: design/tsm_front.sv
// ----------------------------------------------------------------------------
// tsm_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tsm_front #(
    parameter int MAX_CARDS  = 256,
    parameter int TAPE_CELLS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_card_index,
    input  logic [31:0]        i_card_word,
    input  logic [9:0]         i_cell_index,
    input  tsm_pkg::t_back_stat i_back,
    output tsm_pkg::t_item     o_item,
    output logic               o_item_valid
);

    localparam logic [13:0] MaxCardsW  = 14'(MAX_CARDS);
    localparam logic [16:0] TapeCellsW = 17'(TAPE_CELLS);

    tsm_pkg::t_item r_q [2];
    logic           r_wptr, n_wptr;
    logic           r_rptr, n_rptr;
    logic [1:0]     r_count, n_count;
    tsm_pkg::t_item cls;
    logic           accept;

    assign full         = (r_count == 2'd2) || i_back.init_busy;
    assign accept       = push && !full;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rptr];

    always_comb begin
        cls.op         = tsm_pkg::t_op'(i_opcode);
        cls.slot_ok    = ({6'd0, i_card_index} < MaxCardsW);
        cls.card_index = i_card_index;
        cls.card_word  = i_card_word;
        cls.cell_ok    = ({7'd0, i_cell_index} < TapeCellsW);
        cls.cell_index = i_cell_index;
    end

    always_comb begin
        n_wptr  = accept ? !r_wptr : r_wptr;
        n_rptr  = i_back.take ? !r_rptr : r_rptr;
        n_count = r_count + {1'b0, accept} - {1'b0, i_back.take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wptr] <= cls;
        end
    end

endmodule

FILE: design/tsm_back.sv
// ----------------------------------------------------------------------------
// tsm_back
// Executes queued words against the card store and tape, holds one result.
// ----------------------------------------------------------------------------
module tsm_back #(
    parameter int MAX_CARDS  = 256,
    parameter int TAPE_CELLS = 1024,
    parameter int HEAD_START = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [8:0]          i_num_cards,
    input  tsm_pkg::t_item      i_item,
    input  logic                i_item_valid,
    output tsm_pkg::t_back_stat o_stat,
    input  logic                pop,
    output logic                empty,
    output tsm_pkg::t_result    o_result
);

    localparam int TapeAw = $clog2(TAPE_CELLS);
    localparam int CardAw = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
    localparam int StartHead = (HEAD_START >= TAPE_CELLS) ? TAPE_CELLS - 1 : HEAD_START;
    localparam logic [TapeAw-1:0] TapeLast  = TapeAw'(TAPE_CELLS - 1);
    localparam logic [TapeAw-1:0] HeadInit  = TapeAw'(StartHead);
    localparam logic [13:0]       MaxCardsW = 14'(MAX_CARDS);

    logic [31:0] r_cards [MAX_CARDS];
    logic        r_tape  [TAPE_CELLS];
    logic [31:0] r_card_q;
    logic        r_tape_q;

    tsm_pkg::t_back_state r_state, n_state;
    logic [TapeAw-1:0] r_head, n_head;
    logic [13:0]       r_card, n_card;
    logic [TapeAw-1:0] r_clr_addr, n_clr_addr;
    logic              r_restart, n_restart;
    logic              r_out_valid, n_out_valid;
    tsm_pkg::t_result  r_out, n_out;
    // range flag of the read in flight
    logic              r_cell_ok;

    logic              card_we;
    logic [CardAw-1:0] card_waddr, card_raddr;
    logic              tape_we, tape_wdata;
    logic [TapeAw-1:0] tape_waddr, tape_raddr;

    logic [13:0] limit;
    logic        take, step_ok, clr_last;
    logic [15:0] half;
    logic        off_tape;

    assign limit    = (14'(i_num_cards) > MaxCardsW) ? MaxCardsW : 14'(i_num_cards);
    assign take     = (r_state == tsm_pkg::S_IDLE) && i_item_valid && (!r_out_valid || pop);
    assign step_ok  = (r_card != 14'd0) && (r_card <= limit);
    assign clr_last = (r_clr_addr == TapeLast);
    assign half     = r_tape_q ? r_card_q[31:16] : r_card_q[15:0];
    assign off_tape = half[1] ? (r_head == TapeLast) : (r_head == '0);

    assign o_stat.take      = take;
    assign o_stat.init_busy = (r_state == tsm_pkg::S_CLEAR) && !r_restart;
    assign empty            = !r_out_valid;
    assign o_result         = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsm_pkg::S_CLEAR: begin
                if (clr_last) begin
                    n_state = tsm_pkg::S_IDLE;
                end
            end
            tsm_pkg::S_IDLE: begin
                if (take) begin
                    case (i_item.op)
                        tsm_pkg::OP_READ:    n_state = tsm_pkg::S_READ;
                        tsm_pkg::OP_STEP:    n_state = step_ok ? tsm_pkg::S_EXEC : tsm_pkg::S_IDLE;
                        tsm_pkg::OP_RESTART: n_state = tsm_pkg::S_CLEAR;
                        default:             n_state = tsm_pkg::S_IDLE;
                    endcase
                end
            end
            tsm_pkg::S_READ: n_state = tsm_pkg::S_IDLE;
            tsm_pkg::S_EXEC: n_state = tsm_pkg::S_IDLE;
            default:         n_state = tsm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_card      = r_card;
        n_clr_addr  = r_clr_addr;
        n_restart   = r_restart;
        n_out_valid = r_out_valid && !pop;
        n_out       = r_out;
        card_we     = 1'b0;
        card_waddr  = CardAw'(i_item.card_index);
        card_raddr  = CardAw'(r_card - 14'd1);
        tape_we     = 1'b0;
        tape_waddr  = r_clr_addr;
        tape_wdata  = 1'b0;
        tape_raddr  = r_head;
        case (r_state)
            tsm_pkg::S_CLEAR: begin
                tape_we    = 1'b1;
                n_clr_addr = r_clr_addr + TapeAw'(1);
                if (clr_last) begin
                    n_clr_addr = '0;
                    if (r_restart) begin
                        n_out_valid         = 1'b1;
                        n_out.status        = tsm_pkg::ST_OK;
                        n_out.machine_state = r_card;
                        n_out.head_position = 10'(r_head);
                        n_out.cell_value    = 1'b0;
                    end
                end
            end
            tsm_pkg::S_IDLE: begin
                if (i_item.op == tsm_pkg::OP_READ) begin
                    tape_raddr = TapeAw'(i_item.cell_index);
                end
                if (take) begin
                    n_out.status        = tsm_pkg::ST_OK;
                    n_out.machine_state = r_card;
                    n_out.head_position = 10'(r_head);
                    n_out.cell_value    = 1'b0;
                    case (i_item.op)
                        tsm_pkg::OP_LOAD: begin
                            card_we     = i_item.slot_ok;
                            n_out_valid = 1'b1;
                        end
                        tsm_pkg::OP_STEP: begin
                            if (r_card == 14'd0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = tsm_pkg::ST_HALTED;
                            end else if (!step_ok) begin
                                n_out_valid         = 1'b1;
                                n_out.status        = tsm_pkg::ST_BAD_CARD;
                                n_out.machine_state = 14'd0;
                                n_card              = 14'd0;
                            end
                        end
                        tsm_pkg::OP_RESTART: begin
                            n_head     = HeadInit;
                            n_card     = 14'd1;
                            n_restart  = 1'b1;
                            n_clr_addr = '0;
                        end
                        default: begin
                            n_restart = r_restart;
                        end
                    endcase
                end
            end
            tsm_pkg::S_READ: begin
                n_out_valid      = 1'b1;
                n_out.cell_value = r_cell_ok && r_tape_q;
            end
            tsm_pkg::S_EXEC: begin
                tape_we          = 1'b1;
                tape_waddr       = r_head;
                tape_wdata       = half[0];
                n_out_valid      = 1'b1;
                n_out.cell_value = half[0];
                if (off_tape) begin
                    n_card       = 14'd0;
                    n_out.status = tsm_pkg::ST_OFF_TAPE;
                end else begin
                    n_head = half[1] ? r_head + TapeAw'(1) : r_head - TapeAw'(1);
                    if (half[15:2] > limit) begin
                        n_card       = 14'd0;
                        n_out.status = tsm_pkg::ST_BAD_CARD;
                    end else begin
                        n_card       = half[15:2];
                        n_out.status = tsm_pkg::ST_OK;
                    end
                end
                n_out.machine_state = n_card;
                n_out.head_position = 10'(n_head);
            end
            default: begin
                n_out_valid = r_out_valid && !pop;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cell_ok <= i_item.cell_ok;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsm_pkg::S_CLEAR;
            r_head      <= HeadInit;
            r_card      <= 14'd1;
            r_clr_addr  <= '0;
            r_restart   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_card      <= n_card;
            r_clr_addr  <= n_clr_addr;
            r_restart   <= (n_state == tsm_pkg::S_CLEAR) ? n_restart : 1'b0;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (card_we) begin
            r_cards[card_waddr] <= i_item.card_word;
        end
        r_card_q <= r_cards[card_raddr];
        if (tape_we) begin
            r_tape[tape_waddr] <= tape_wdata;
        end
        r_tape_q <= r_tape[tape_raddr];
    end

endmodule

FILE: design/two_symbol_turing_machine_stepper_unit.sv
// ----------------------------------------------------------------------------
// two_symbol_turing_machine_stepper_unit
// Binary-tape Turing machine run from a table of 32-bit cards.
//
//   Channel  Handshake              Payload
//   input    push / full            i_opcode, i_card_index, i_card_word,
//                                   i_cell_index
//   result   empty / pop            o_status, o_machine_state,
//                                   o_head_position, o_cell_value
//   config   i_cfg_valid/o_cfg_ready i_cfg_data (num_cards)
//
// Load, halted or bad-card step: result registered from idle. Read cell: tape
// read in idle, result in S_READ. Step: card/tape memory read, then tape
// write-back and result in S_EXEC. Restart: one tape cell cleared per cycle.
// After reset the tape is swept clear; full stays high during the sweep.
// A two-entry input queue and one result register decouple the sides.
// ----------------------------------------------------------------------------
module two_symbol_turing_machine_stepper_unit #(
    parameter int MAX_CARDS  = 256,
    parameter int TAPE_CELLS = 1024,
    parameter int HEAD_START = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_card_index,
    input  logic [31:0] i_card_word,
    input  logic [9:0]  i_cell_index,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [13:0] o_machine_state,
    output logic [9:0]  o_head_position,
    output logic        o_cell_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    logic [8:0]          r_num_cards;
    tsm_pkg::t_item      item;
    logic                item_valid;
    tsm_pkg::t_back_stat back_stat;
    tsm_pkg::t_result    result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cards <= 9'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_cards <= i_cfg_data;
        end
    end

    tsm_front #(
        .MAX_CARDS  (MAX_CARDS),
        .TAPE_CELLS (TAPE_CELLS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_card_index (i_card_index),
        .i_card_word  (i_card_word),
        .i_cell_index (i_cell_index),
        .i_back       (back_stat),
        .o_item       (item),
        .o_item_valid (item_valid)
    );

    tsm_back #(
        .MAX_CARDS  (MAX_CARDS),
        .TAPE_CELLS (TAPE_CELLS),
        .HEAD_START (HEAD_START)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_cards  (r_num_cards),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_stat       (back_stat),
        .pop          (pop),
        .empty        (empty),
        .o_result     (result)
    );

    assign o_status        = result.status;
    assign o_machine_state = result.machine_state;
    assign o_head_position = result.head_position;
    assign o_cell_value    = result.cell_value;

    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.init_busy |-> full)
        else $error("input open during tape sweep");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == tsm_pkg::ST_HALTED || o_status == tsm_pkg::ST_OFF_TAPE ||
                    o_status == tsm_pkg::ST_BAD_CARD)) |-> (o_machine_state == 14'd0))
        else $error("error status with running machine");

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.take |-> (item_valid && (empty || pop)))
        else $error("back took word without room");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-symbol Turing machine stepper. Commands
// are queued per phase, pushed into the block with random gaps, and run
// through a cycle-free machine model at the moment of acceptance; every
// popped result word is compared field by field with the oldest prediction.
// Phases cover directed cards, walks to both tape edges, and random programs
// under several card counts.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CARD_SLOTS = 256;
    localparam int TAPE_LEN   = 1024;
    localparam int HEAD_HOME  = 512;

    typedef struct {
        tsm_pkg::t_op op;
        logic [7:0]   slot;
        logic [31:0]  word;
        logic [9:0]   cell_idx;
    } t_tm_command;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_opcode = '0;
    logic [7:0]  i_card_index = '0;
    logic [31:0] i_card_word = '0;
    logic [9:0]  i_cell_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [13:0] o_machine_state;
    logic [9:0]  o_head_position;
    logic        o_cell_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data = '0;

    two_symbol_turing_machine_stepper_unit #(
        .MAX_CARDS (CARD_SLOTS),
        .TAPE_CELLS(TAPE_LEN),
        .HEAD_START(HEAD_HOME)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_card_index   (i_card_index),
        .i_card_word    (i_card_word),
        .i_cell_index   (i_cell_index),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_machine_state(o_machine_state),
        .o_head_position(o_head_position),
        .o_cell_value   (o_cell_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // machine model state
    logic [31:0] card_mem [CARD_SLOTS];
    bit          tape [TAPE_LEN];
    logic [9:0]  head_pos = 10'(HEAD_HOME);
    logic [13:0] cur_card = 14'd1;
    logic [8:0]  card_count = 9'd1;

    // stimulus side
    t_tm_command      commands_q[$];
    tsm_pkg::t_result reports_due[$];
    bit               slot_loaded [CARD_SLOTS];
    int               loaded_cards[$];
    bit               word_taken = 1'b0;
    bit               send_calm = 1'b0;
    bit               rcv_calm = 1'b0;
    bit               quiet_tail = 1'b0;
    bit               hold_results = 1'b0;
    int               send_gap = 0;
    int               rcv_gap = 0;
    int               n_accepted = 0;
    int               n_results = 0;
    int               n_errors = 0;

    function automatic tsm_pkg::t_result advance_machine(input t_tm_command c);
        tsm_pkg::t_result r;
        logic [15:0]      half;
        logic [13:0]      nxt;
        int               lim;
        r = '0;
        r.status = tsm_pkg::ST_OK;
        lim = (card_count > CARD_SLOTS) ? CARD_SLOTS : int'(card_count);
        case (c.op)
            tsm_pkg::OP_LOAD: begin
                card_mem[c.slot] = c.word;
            end
            tsm_pkg::OP_STEP: begin
                if (cur_card == 0) begin
                    r.status = tsm_pkg::ST_HALTED;
                end else if (cur_card > lim) begin
                    r.status = tsm_pkg::ST_BAD_CARD;
                    cur_card = '0;
                end else begin
                    half = tape[head_pos] ? card_mem[cur_card - 14'd1][31:16]
                                          : card_mem[cur_card - 14'd1][15:0];
                    nxt = half[15:2];
                    tape[head_pos] = half[0];
                    r.cell_value = half[0];
                    if (half[1] ? (head_pos == TAPE_LEN - 1) : (head_pos == 0)) begin
                        r.status = tsm_pkg::ST_OFF_TAPE;
                        cur_card = '0;
                    end else begin
                        head_pos = half[1] ? head_pos + 10'd1 : head_pos - 10'd1;
                        if (nxt > lim) begin
                            r.status = tsm_pkg::ST_BAD_CARD;
                            cur_card = '0;
                        end else begin
                            cur_card = nxt;
                        end
                    end
                end
            end
            tsm_pkg::OP_READ: begin
                r.cell_value = tape[c.cell_idx];
            end
            default: begin
                tape = '{default: 1'b0};
                head_pos = 10'(HEAD_HOME);
                cur_card = 14'd1;
            end
        endcase
        r.machine_state = cur_card;
        r.head_position = head_pos;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("MISMATCH result %0d %s: got %0h, expected %0h",
                 n_results, what, got, want);
    endtask

    // ---- input side ----
    always @(posedge i_clk) begin : accept_words
        t_tm_command c;
        if (!i_rst_n) begin
            word_taken = 1'b0;
        end else begin
            word_taken = push && !full;
            if (word_taken) begin
                c = commands_q.pop_front();
                reports_due.push_back(advance_machine(c));
                n_accepted++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !word_taken) begin
            // word still waiting for acceptance
        end else if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
        end else if (commands_q.size() == 0) begin
            push <= 1'b0;
        end else if (!send_calm && !quiet_tail && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 16);
            push <= 1'b0;
        end else begin
            push <= 1'b1;
            i_opcode <= commands_q[0].op;
            i_card_index <= commands_q[0].slot;
            i_card_word <= commands_q[0].word;
            i_cell_index <= commands_q[0].cell_idx;
        end
    end

    // ---- result side ----
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_results) begin
            pop <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            pop <= 1'b0;
        end else if (!rcv_calm && !quiet_tail && $urandom_range(0, 9) == 0) begin
            rcv_gap = $urandom_range(0, 16);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        tsm_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (reports_due.size() == 0) begin
                report_mismatch("word with nothing expected", 32'(o_machine_state), '0);
            end else begin
                want = reports_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_machine_state !== want.machine_state)
                    report_mismatch("machine_state", 32'(o_machine_state),
                                    32'(want.machine_state));
                if (o_head_position !== want.head_position)
                    report_mismatch("head_position", 32'(o_head_position),
                                    32'(want.head_position));
                if (o_cell_value !== want.cell_value)
                    report_mismatch("cell_value", 32'(o_cell_value), 32'(want.cell_value));
            end
            n_results++;
        end
    end

    // long receiver stall while the sender keeps offering
    initial begin : receiver_hold
        while (!(n_accepted >= 100 && commands_q.size() > 50)) @(posedge i_clk);
        hold_results = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_results = 1'b0;
    end

    initial begin : watchdog
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // ---- stimulus generation ----
    function automatic t_tm_command blank_command(input tsm_pkg::t_op op);
        t_tm_command c;
        c.op = op;
        c.slot = 8'($urandom);
        c.word = $urandom;
        c.cell_idx = 10'($urandom);
        return c;
    endfunction

    // next card is one in 1..span if span is set, else halt, a card that is bad under any count, or a loaded card
    function automatic logic [15:0] random_half(input int mv, input int span);
        logic [13:0] nxt;
        int          pick;
        pick = $urandom_range(0, 19);
        if (span > 0)
            nxt = 14'($urandom_range(1, span));
        else if (pick == 0)
            nxt = '0;
        else if (pick == 1)
            nxt = 14'($urandom_range(CARD_SLOTS + 1, 16383));
        else
            nxt = 14'(loaded_cards[$urandom_range(0, loaded_cards.size() - 1)]);
        return {nxt, (mv > 1) ? 1'($urandom_range(0, 1)) : 1'(mv),
                1'($urandom_range(0, 1))};
    endfunction

    function automatic void mark_loaded(input int slot);
        if (!slot_loaded[slot]) begin
            slot_loaded[slot] = 1'b1;
            loaded_cards.push_back(slot + 1);
        end
    endfunction

    function automatic void load_card(input int slot, input int mv, input int span);
        t_tm_command c;
        mark_loaded(slot);
        c = blank_command(tsm_pkg::OP_LOAD);
        c.slot = 8'(slot);
        c.word = {random_half(mv, span), random_half(mv, span)};
        commands_q.push_back(c);
    endfunction

    function automatic void load_fixed(input int slot, input logic [31:0] word);
        t_tm_command c;
        mark_loaded(slot);
        c = blank_command(tsm_pkg::OP_LOAD);
        c.slot = 8'(slot);
        c.word = word;
        commands_q.push_back(c);
    endfunction

    function automatic void read_cell(input int idx);
        t_tm_command c;
        c = blank_command(tsm_pkg::OP_READ);
        c.cell_idx = 10'(idx);
        commands_q.push_back(c);
    endfunction

    task automatic write_card_count(input int n);
        while (commands_q.size() != 0 || reports_due.size() != 0 || push)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= 9'(n);
        do @(posedge i_clk); while (!o_cfg_ready);
        card_count = 9'(n);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        send_calm = ($urandom_range(0, 3) == 0);
        rcv_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic walk_to_edge(input int mv);
        for (int s = 0; s < 8; s++) load_card(s, mv, 8);
        commands_q.push_back(blank_command(tsm_pkg::OP_RESTART));
        repeat (540) begin
            if ($urandom_range(0, 31) == 0)
                commands_q.push_back(blank_command(tsm_pkg::OP_READ));
            else
                commands_q.push_back(blank_command(tsm_pkg::OP_STEP));
        end
    endtask

    task automatic random_phase(input int n_cards, input int n_items);
        int lim;
        int pick;
        write_card_count(n_cards);
        lim = (n_cards > CARD_SLOTS) ? CARD_SLOTS : n_cards;
        if ($urandom_range(0, 1) == 0)
            commands_q.push_back(blank_command(tsm_pkg::OP_RESTART));
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                commands_q.push_back(blank_command(tsm_pkg::OP_RESTART));
            else if (pick < 24)
                load_card((lim > 0 && $urandom_range(0, 1) == 0) ? $urandom_range(0, lim - 1)
                                                                 : $urandom_range(0, 255),
                          2, 0);
            else if (pick < 40)
                read_cell($urandom_range(0, 1) ? $urandom_range(0, TAPE_LEN - 1)
                                               : $urandom_range(480, 544));
            else
                commands_q.push_back(blank_command(tsm_pkg::OP_STEP));
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed cards and a short hand-traced program
        write_card_count(4);
        load_fixed(0, {16'h000C, 16'h000B});
        load_fixed(1, {16'h0003, 16'h0005});
        load_fixed(2, {16'hFFFF, 16'h04B3});
        load_fixed(3, {16'h0010, 16'h0012});
        load_fixed(255, 32'hFFFF_FFFF);
        load_fixed(254, 32'h0000_0000);
        read_cell(HEAD_HOME);
        read_cell(0);
        read_cell(TAPE_LEN - 1);
        repeat (5) commands_q.push_back(blank_command(tsm_pkg::OP_STEP));
        read_cell(HEAD_HOME - 1);
        read_cell(HEAD_HOME);
        commands_q.push_back(blank_command(tsm_pkg::OP_RESTART));
        read_cell(HEAD_HOME - 1);
        repeat (6) commands_q.push_back(blank_command(tsm_pkg::OP_STEP));
        read_cell(HEAD_HOME + 1);

        // both tape edges
        write_card_count(8);
        walk_to_edge(0);
        walk_to_edge(1);

        random_phase(256, 60);
        random_phase(1, 40);
        random_phase(0, 25);
        random_phase(511, 60);
        random_phase(17, 40);
        while (commands_q.size() != 0 || reports_due.size() != 0 || push)
            @(posedge i_clk);
        quiet_tail = 1'b1;
        random_phase(3, 50);

        while (commands_q.size() != 0 || reports_due.size() != 0) @(posedge i_clk);
        repeat (TAPE_LEN + 16) @(posedge i_clk);

        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
